// ===== src/aes_pkg.sv =====
// Shared types, constants and byte functions of the AES-128 encryption block.
package aes_pkg;

    typedef struct packed {
        logic [63:0] block_high;
        logic [63:0] block_low;
    } t_in;

    typedef struct packed {
        logic [63:0] cipher_high;
        logic [63:0] cipher_low;
    } t_out;

    // Controller to datapath commands
    typedef struct packed {
        logic load;    // take input block and key, do initial key addition
        logic round;   // apply one round
        logic last;    // this round skips MixColumns
        logic capture; // move state into the output register
    } t_cmd;

    localparam logic [0:0] CFG_KEY_HIGH = 1'b0;
    localparam logic [0:0] CFG_KEY_LOW  = 1'b1;
    localparam int         NUM_ROUNDS   = 10;
    localparam logic [7:0] RCON_INIT    = 8'h01;

    function automatic logic [7:0] xtime(input logic [7:0] x);
        xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1B : 8'h00);
    endfunction

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] s [256];
        s = '{
            8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
            8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
            8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
            8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
            8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
            8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
            8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
            8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
            8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
            8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
            8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
            8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
            8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
            8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
            8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
            8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        sbox = s[x];
    endfunction

endpackage

// ===== src/aes_ctrl.sv =====
// Round sequencer of the AES-128 encryption block.
module aes_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  logic          i_out_stall,
    output logic          o_out_valid,
    output aes_pkg::t_cmd o_cmd
);
    typedef enum logic [1:0] {S_IDLE, S_RUN, S_DONE} t_state;

    t_state     r_state, n_state;
    logic [3:0] r_round, n_round;
    logic       r_out_valid, n_out_valid;

    // a new request is taken while idle, or while the result is being handed off
    logic out_free;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = !(r_state == S_IDLE || (r_state == S_DONE && out_free));

    always_comb begin
        n_state     = r_state;
        n_round     = r_round;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_round    = 4'd1;
                    n_state    = S_RUN;
                end
            end
            S_RUN: begin
                o_cmd.round = 1'b1;
                o_cmd.last  = (r_round == 4'(aes_pkg::NUM_ROUNDS));
                n_round     = r_round + 4'd1;
                if (o_cmd.last) n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.capture = 1'b1;
                    n_out_valid   = 1'b1;
                    n_state       = S_IDLE;
                    if (i_in_valid) begin
                        o_cmd.load = 1'b1;
                        n_round    = 4'd1;
                        n_state    = S_RUN;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_round     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_round     <= n_round;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
endmodule

// ===== src/aes_dp.sv =====
// State, round key and output registers of the AES-128 encryption block.
module aes_dp (
    input  logic           i_clk,
    input  aes_pkg::t_cmd  i_cmd,
    input  aes_pkg::t_in   i_in,
    input  logic [127:0]   i_key,
    output aes_pkg::t_out  o_out
);
    logic [127:0] r_state, n_state;
    logic [127:0] r_rkey, n_rkey;
    logic [7:0]   r_rcon, n_rcon;
    logic [127:0] r_out;

    logic [7:0] st [16];
    logic [7:0] sr [16];
    logic [7:0] mc [16];
    logic [31:0] w [4];
    logic [31:0] nw [4];
    logic [31:0] tw;
    logic [127:0] mixed, next_key;

    always_comb begin
        for (int i = 0; i < 16; i++) st[i] = r_state[127 - 8*i -: 8];
        // SubBytes with ShiftRows
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                sr[4*c + r] = aes_pkg::sbox(st[4*((c + r) % 4) + r]);
        for (int c = 0; c < 4; c++) begin
            logic [7:0] a0, a1, a2, a3, al;
            a0 = sr[4*c]; a1 = sr[4*c+1]; a2 = sr[4*c+2]; a3 = sr[4*c+3];
            al = a0 ^ a1 ^ a2 ^ a3;
            mc[4*c]   = a0 ^ al ^ aes_pkg::xtime(a0 ^ a1);
            mc[4*c+1] = a1 ^ al ^ aes_pkg::xtime(a1 ^ a2);
            mc[4*c+2] = a2 ^ al ^ aes_pkg::xtime(a2 ^ a3);
            mc[4*c+3] = a3 ^ al ^ aes_pkg::xtime(a3 ^ a0);
        end
        for (int i = 0; i < 16; i++)
            mixed[127 - 8*i -: 8] = i_cmd.last ? sr[i] : mc[i];
        // next round key
        for (int i = 0; i < 4; i++) w[i] = r_rkey[127 - 32*i -: 32];
        tw = {aes_pkg::sbox(w[3][23:16]) ^ r_rcon, aes_pkg::sbox(w[3][15:8]),
              aes_pkg::sbox(w[3][7:0]), aes_pkg::sbox(w[3][31:24])};
        nw[0] = w[0] ^ tw;
        for (int i = 1; i < 4; i++) nw[i] = w[i] ^ nw[i-1];
        next_key = {nw[0], nw[1], nw[2], nw[3]};

        n_state = r_state;
        n_rkey  = r_rkey;
        n_rcon  = r_rcon;
        if (i_cmd.load) begin
            n_state = i_in ^ i_key;
            n_rkey  = i_key;
            n_rcon  = aes_pkg::RCON_INIT;
        end else if (i_cmd.round) begin
            n_state = mixed ^ next_key;
            n_rkey  = next_key;
            n_rcon  = aes_pkg::xtime(r_rcon);
        end
    end

    always_ff @(posedge i_clk) begin
        r_state <= n_state;
        r_rkey  <= n_rkey;
        r_rcon  <= n_rcon;
        if (i_cmd.capture) r_out <= r_state;
    end

    assign o_out = r_out;
endmodule

// ===== src/aes128_block_encrypt.sv =====
// Top level of the AES-128 block encryption unit.
// Encrypts one 128-bit block per request under the key held in registers 0 (high half)
// and 1 (low half). After acceptance come the initial key addition at the accepting
// edge, then ten rounds on a single round unit that also expands the next round key
// on the fly, then a transfer into the output register once the previous result has
// been taken. The next request is taken in the cycle its predecessor moves to the
// output register.
module aes128_block_encrypt (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  aes_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output aes_pkg::t_out o_out_data,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic          i_cfg_index,
    input  logic [63:0]   i_cfg_data
);
    logic [63:0]   r_key_high, r_key_low;
    aes_pkg::t_cmd cmd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                aes_pkg::CFG_KEY_HIGH: r_key_high <= i_cfg_data;
                aes_pkg::CFG_KEY_LOW:  r_key_low  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    aes_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    aes_dp u_dp (
        .i_clk (i_clk),
        .i_cmd (cmd),
        .i_in  (i_in_data),
        .i_key ({r_key_high, r_key_low}),
        .o_out (o_out_data)
    );

    a_load_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) == cmd.load)
        else $error("load command out of step with input acceptance");
    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.load && cmd.round))
        else $error("load and round issued together");
    a_capture_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.capture |=> o_out_valid)
        else $error("captured result not presented");
    a_last_then_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.last |-> !cmd.capture)
        else $error("capture in final round cycle");
endmodule

// ===== dv/aes_checker.sv =====
// Checker for the AES-128 encryption block: predicts ciphertext from requests and compares.
`timescale 1ns / 100ps
module aes_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_stall,
    input  aes_pkg::t_in  i_in_data,
    input  logic          i_out_valid,
    input  logic          i_out_stall,
    input  aes_pkg::t_out i_out_data,
    input  logic          i_cfg_valid,
    input  logic          i_cfg_ready,
    input  logic          i_cfg_index,
    input  logic [63:0]   i_cfg_data,
    output int            o_fail_count,
    output int            o_pending,
    output int            o_results_seen
);
    logic [63:0]   key_hi_q, key_lo_q;
    aes_pkg::t_out cipher_queue [$];

    function automatic logic [7:0] gmul2(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1B : 8'h00);
    endfunction

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        acc = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[0]) acc = acc ^ a;
            a = gmul2(a);
            b = b >> 1;
        end
        return acc;
    endfunction

    // inverse as x^254, then the affine map
    function automatic logic [7:0] subst(input logic [7:0] x);
        logic [7:0] sq, acc, p;
        sq = gmul(x, x);
        acc = sq;
        p = sq;
        for (int i = 0; i < 6; i++) begin
            p = gmul(p, p);
            acc = gmul(acc, p);
        end
        return acc ^ {acc[6:0], acc[7]} ^ {acc[5:0], acc[7:6]} ^ {acc[4:0], acc[7:5]}
               ^ {acc[3:0], acc[7:4]} ^ 8'h63;
    endfunction

    function automatic aes_pkg::t_out encrypt(input aes_pkg::t_in blk,
                                              input logic [63:0] khi,
                                              input logic [63:0] klo);
        logic [7:0] rk [176];
        logic [7:0] st [16];
        logic [7:0] tmp [16];
        logic [7:0] w [4];
        logic [7:0] f, rc, a0, a1, a2, a3, all;
        logic [127:0] kv, bv, ov;
        aes_pkg::t_out res;
        kv = {khi, klo};
        bv = blk;
        rc = 8'h01;
        for (int i = 0; i < 16; i++) begin
            rk[i] = kv[127 - 8*i -: 8];
            st[i] = bv[127 - 8*i -: 8];
        end
        for (int i = 4; i < 44; i++) begin
            for (int j = 0; j < 4; j++) w[j] = rk[4*(i-1)+j];
            if (i % 4 == 0) begin
                f = w[0];
                w[0] = subst(w[1]) ^ rc;
                w[1] = subst(w[2]);
                w[2] = subst(w[3]);
                w[3] = subst(f);
                rc = gmul2(rc);
            end
            for (int j = 0; j < 4; j++) rk[4*i+j] = rk[4*(i-4)+j] ^ w[j];
        end
        for (int i = 0; i < 16; i++) st[i] ^= rk[i];
        for (int rnd = 1; rnd <= aes_pkg::NUM_ROUNDS; rnd++) begin
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                    tmp[4*c+r] = subst(st[4*((c+r)%4)+r]);
            st = tmp;
            if (rnd != aes_pkg::NUM_ROUNDS) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = st[4*c]; a1 = st[4*c+1]; a2 = st[4*c+2]; a3 = st[4*c+3];
                    all = a0 ^ a1 ^ a2 ^ a3;
                    st[4*c]   = a0 ^ all ^ gmul2(a0 ^ a1);
                    st[4*c+1] = a1 ^ all ^ gmul2(a1 ^ a2);
                    st[4*c+2] = a2 ^ all ^ gmul2(a2 ^ a3);
                    st[4*c+3] = a3 ^ all ^ gmul2(a3 ^ a0);
                end
            end
            for (int i = 0; i < 16; i++) st[i] ^= rk[16*rnd+i];
        end
        for (int i = 0; i < 16; i++) ov[127 - 8*i -: 8] = st[i];
        res = ov;
        return res;
    endfunction

    assign o_pending = cipher_queue.size();

    always @(posedge i_clk) begin
        aes_pkg::t_out exp_c;
        int errs;
        errs = 0;
        if (!i_rst_n) begin
            key_hi_q <= '0;
            key_lo_q <= '0;
            o_fail_count <= 0;
            o_results_seen <= 0;
            cipher_queue.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == aes_pkg::CFG_KEY_HIGH) key_hi_q <= i_cfg_data;
                else key_lo_q <= i_cfg_data;
            end
            if (i_in_valid && !i_in_stall)
                cipher_queue.push_back(encrypt(i_in_data, key_hi_q, key_lo_q));
            if (i_out_valid && !i_out_stall) begin
                o_results_seen <= o_results_seen + 1;
                if (cipher_queue.size() == 0) begin
                    $error("unexpected result %h", i_out_data);
                    errs++;
                end else begin
                    exp_c = cipher_queue.pop_front();
                    if (exp_c.cipher_high !== i_out_data.cipher_high) begin
                        $error("cipher_high: expected %h actual %h",
                               exp_c.cipher_high, i_out_data.cipher_high);
                        errs++;
                    end
                    if (exp_c.cipher_low !== i_out_data.cipher_low) begin
                        $error("cipher_low: expected %h actual %h",
                               exp_c.cipher_low, i_out_data.cipher_low);
                        errs++;
                    end
                end
            end
            o_fail_count <= o_fail_count + errs;
        end
    end
endmodule

// ===== dv/testbench.sv =====
// Testbench top for the AES-128 encryption block: stimulus, key phases and verdict.
`timescale 1ns / 100ps
module testbench;
    localparam int IDLE_LIMIT = 20000;
    localparam int N_RANDOM   = 830;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          in_valid = 1'b0;
    logic          in_stall;
    aes_pkg::t_in  in_data = '0;
    logic          out_valid;
    logic          out_stall = 1'b0;
    aes_pkg::t_out out_data;
    logic          cfg_valid = 1'b0;
    logic          cfg_ready;
    logic          cfg_index = aes_pkg::CFG_KEY_HIGH;
    logic [63:0]   cfg_data = '0;
    int            fail_count, pending, results_seen;
    int            idle_cycles = 0;
    int            blocks_sent = 0;
    int            key_writes = 0;
    bit            stim_done = 1'b0;

    always #1 i_clk = ~i_clk;

    aes128_block_encrypt dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_data(out_data),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    aes_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out_data(out_data),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending), .o_results_seen(results_seen)
    );

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
        return 0;
    endfunction

    function automatic logic [63:0] rand64();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return 64'h1 << $urandom_range(0, 63);
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    // receiver stall: mostly short, a few long, and quiet stretches
    always @(posedge i_clk) begin
        int hold;
        if (hold > 0) begin
            hold = hold - 1;
        end else if (results_seen > 300 && results_seen < 400) begin
            out_stall <= 1'b0;
        end else begin
            hold = gap_len();
            out_stall <= (hold > 0);
        end
    end

    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no traffic for %0d cycles", IDLE_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    // valid stays high after acceptance until the next request, a gap or a drain replaces it
    task automatic send_block(input logic [63:0] hi, input logic [63:0] lo);
        int g;
        g = gap_len();
        if (g > 0) begin
            in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data <= '{block_high: hi, block_low: lo};
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        blocks_sent++;
    endtask

    task automatic write_key(input logic idx, input logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        key_writes++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic set_key(input logic [63:0] hi, input logic [63:0] lo);
        drain();
        write_key(aes_pkg::CFG_KEY_HIGH, hi);
        write_key(aes_pkg::CFG_KEY_LOW, lo);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // default all-zero key first
        send_block('0, '0);
        send_block('1, '1);
        // FIPS-197 appendix vector
        set_key(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c);
        send_block(64'h3243f6a8885a308d, 64'h313198a2e0370734);
        send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
        set_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
        send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
        send_block('0, '1);
        send_block('1, '0);
        set_key('1, '1);
        send_block('0, '0);
        send_block('1, '1);
        send_block(64'h8000000000000000, 64'h1);
        set_key('0, '1);
        send_block(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
        send_block(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i % 80 == 40) set_key(rand64(), rand64());
            send_block(rand64(), rand64());
        end
        drain();
        stim_done = 1'b1;
        $display("covered %0d blocks, %0d results, %0d key writes over several keys",
                 blocks_sent, results_seen, key_writes);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

// ===== files.f =====
src/aes_pkg.sv
src/aes_ctrl.sv
src/aes_dp.sv
src/aes128_block_encrypt.sv
dv/aes_checker.sv
dv/testbench.sv
